>>> rtl/hkse_pkg.sv
// Shared types and constants for the hashed key set engine.
// Request and response payloads, controller command and status structs.
// No dependencies.
package hkse_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	localparam logic [31:0] MUL_A = 32'h7feb352d;
	localparam logic [31:0] MUL_B = 32'h846ca68b;

	localparam logic [8:0] BUCKET_COUNT_RESET = 9'd256;
	localparam int DIV_STEPS = 8;
	localparam int DIV_BITS = 4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] key;
	} req_t;

	typedef struct packed {
		logic       status;
		logic       found;
		logic [7:0] bucket_id;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic hash;
		logic div_step;
		logic rd;
		logic wr;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic div_done;
	} stat_t;

endpackage

>>> rtl/hkse_ctrl.sv
// Controller state machine for the hashed key set engine.
// Drives datapath commands and both handshakes; depends on hkse_pkg.
module hkse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  hkse_pkg::stat_t stat,
	output hkse_pkg::cmd_t  cmd
);
	import hkse_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_READ  = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   advance;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign advance   = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.hash = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (advance) begin
					cmd.wr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wr) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/hkse_datapath.sv
// Datapath for the hashed key set engine: hash multiplies, remainder unit,
// bucket row memory with clearing sweep, slot compare and response register.
// Depends on hkse_pkg.
module hkse_datapath #(
	parameter int MAX_BUCKETS = 256,
	parameter int SLOTS_PER_BUCKET = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [8:0]     cfg_wr_data,
	input  hkse_pkg::req_t  req,
	input  hkse_pkg::cmd_t  cmd,
	output hkse_pkg::stat_t stat,
	output hkse_pkg::rsp_t  rsp
);
	import hkse_pkg::*;

	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int CW = $clog2(DIV_STEPS);

	logic [8:0]  bucket_count_q;
	logic [31:0] key_q, p1_q, h_q;
	logic [1:0]  op_q;
	logic [9:0]  rem_q, rem_d, n_eff;
	logic [CW-1:0] cnt_q;
	logic [BW-1:0] clr_q, bucket;
	logic [31:0] rem32, x1, x2, p2;

	logic [SLOTS_PER_BUCKET-1:0][32:0] mem [MAX_BUCKETS];
	logic [SLOTS_PER_BUCKET-1:0][32:0] row_q, row_new;

	logic [SLOTS_PER_BUCKET-1:0] hit_vec, free_vec;
	logic          any_hit, any_free;
	logic [SW-1:0] hit_idx, free_idx;
	logic          st_d, fd_d;

	always_comb begin
		if (bucket_count_q == 9'd0) n_eff = 10'd1;
		else if (32'(bucket_count_q) > MAX_BUCKETS) n_eff = 10'(MAX_BUCKETS);
		else n_eff = {1'b0, bucket_count_q};
	end

	assign x1 = req.key ^ (req.key >> 16);
	assign x2 = p1_q ^ (p1_q >> 15);
	assign p2 = x2 * MUL_B;

	always_comb begin
		logic [10:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[9:0], h_q[31-i]};
			if (r >= {1'b0, n_eff}) r = r - {1'b0, n_eff};
		end
		rem_d = r[9:0];
	end

	assign rem32  = 32'(rem_q);
	assign bucket = rem32[BW-1:0];

	assign stat.clear_done = (32'(clr_q) == MAX_BUCKETS - 1);
	assign stat.div_done   = (cnt_q == CW'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_wr_en) bucket_count_q <= cfg_wr_data;
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.hash) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= req.key;
			op_q  <= req.req_type;
			p1_q  <= x1 * MUL_A;
		end
		if (cmd.hash) begin
			h_q   <= p2 ^ (p2 >> 16);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			h_q   <= h_q << DIV_BITS;
			rem_q <= rem_d;
		end
	end

	always_comb begin
		any_hit = 1'b0;
		any_free = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
			hit_vec[s]  = row_q[s][32] && (row_q[s][31:0] == key_q);
			free_vec[s] = !row_q[s][32];
		end
		for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
			if (hit_vec[s]) begin
				any_hit = 1'b1;
				hit_idx = SW'(s);
			end
			if (free_vec[s]) begin
				any_free = 1'b1;
				free_idx = SW'(s);
			end
		end
		row_new = row_q;
		st_d = 1'b0;
		fd_d = 1'b0;
		case (op_q)
			REQ_INSERT: begin
				if (!any_hit) begin
					if (any_free) row_new[free_idx] = {1'b1, key_q};
					else st_d = 1'b1;
				end
			end
			REQ_LOOKUP: fd_d = any_hit;
			REQ_DELETE: if (any_hit) row_new[hit_idx][32] = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) mem[clr_q] <= '0;
		else if (cmd.wr) mem[bucket] <= row_new;
		if (cmd.rd) row_q <= mem[bucket];
		if (cmd.wr) begin
			rsp.status    <= st_d;
			rsp.found     <= fd_d;
			rsp.bucket_id <= rem32[7:0];
		end
	end

endmodule

>>> rtl/hashed_key_set_engine.sv
// Hashed key set engine: one request in flight, one response per request.
// The first hash multiply of a request is registered at the accepting edge;
// then follow the second multiply, the remainder unit (four quotient bits a
// cycle), the bucket row read and the compare and write-back, which loads the
// response. The next request can be taken in the cycle after the response is
// loaded; a stalled response holds the following request in its write-back
// state. After reset a clearing sweep over all MAX_BUCKETS buckets empties the
// table; requests stall until it ends, configuration writes are taken at any
// time.
// Depends on hkse_pkg, hkse_ctrl and hkse_datapath.
module hashed_key_set_engine #(
	parameter int MAX_BUCKETS = 256,
	parameter int SLOTS_PER_BUCKET = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [8:0]    cfg_wr_data,
	input  logic          req_valid,
	output logic          req_stall,
	input  hkse_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hkse_pkg::rsp_t rsp
);
	import hkse_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	hkse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	hkse_datapath #(
		.MAX_BUCKETS      (MAX_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.cmd         (cmd),
		.stat        (stat),
		.rsp         (rsp)
	);

endmodule

>>> rtl/hkse_checker.sv
// Port-level checks for the hashed key set engine, bound to the top level.
// Depends on hkse_pkg.
module hkse_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input hkse_pkg::rsp_t rsp
);
	import hkse_pkg::*;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in progress");

	a_status_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.status && rsp.found))
		else $error("error and found both set");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind hashed_key_set_engine hkse_checker u_hkse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

>>> dv/hashed_key_set_engine_chk.sv
// Checker for the hashed key set engine: watches request, response and
// configuration ports, predicts each response and compares it field by field.
// Depends on hkse_pkg.
module hashed_key_set_engine_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [8:0]     cfg_wr_data,
	input  logic           req_valid,
	input  logic           req_stall,
	input  hkse_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  hkse_pkg::rsp_t rsp,
	output int             fail_count,
	output int             pending
);
	import hkse_pkg::*;

	localparam int NBUCK = 256;
	localparam int NSLOT = 4;

	logic [31:0] tbl_key [NBUCK*NSLOT];
	logic        tbl_used [NBUCK*NSLOT];
	logic [8:0]  nbuckets;
	rsp_t        want_q [$];

	function automatic logic [31:0] mix_key(input logic [31:0] v);
		logic [31:0] x;
		x = v;
		x = x ^ (x >> 16);
		x = x * MUL_A;
		x = x ^ (x >> 15);
		x = x * MUL_B;
		x = x ^ (x >> 16);
		return x;
	endfunction

	task automatic apply_request(input req_t r);
		int n, b, hit, fr, e;
		rsp_t o;
		n = nbuckets;
		if (n == 0) n = 1;
		if (n > NBUCK) n = NBUCK;
		b = mix_key(r.key) % n;
		hit = -1;
		fr = -1;
		for (int s = 0; s < NSLOT; s++) begin
			e = b * NSLOT + s;
			if (tbl_used[e]) begin
				if (hit < 0 && tbl_key[e] == r.key) hit = s;
			end else if (fr < 0) begin
				fr = s;
			end
		end
		o = '0;
		o.bucket_id = b[7:0];
		if (r.req_type == REQ_INSERT) begin
			if (hit < 0) begin
				if (fr >= 0) begin
					tbl_key[b*NSLOT+fr] = r.key;
					tbl_used[b*NSLOT+fr] = 1'b1;
				end else begin
					o.status = 1'b1;
				end
			end
		end else if (r.req_type == REQ_LOOKUP) begin
			o.found = (hit >= 0);
		end else if (r.req_type == REQ_DELETE) begin
			if (hit >= 0) tbl_used[b*NSLOT+hit] = 1'b0;
		end
		want_q.push_back(o);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		nbuckets = BUCKET_COUNT_RESET;
		for (int i = 0; i < NBUCK*NSLOT; i++) begin
			tbl_used[i] = 1'b0;
			tbl_key[i] = '0;
		end
	end

	always @(posedge clk) begin
		rsp_t w;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (want_q.size() == 0) begin
					report("unexpected response", rsp, 0);
				end else begin
					w = want_q.pop_front();
					if (rsp.status !== w.status) report("status", rsp.status, w.status);
					if (rsp.found !== w.found) report("found", rsp.found, w.found);
					if (rsp.bucket_id !== w.bucket_id)
						report("bucket_id", rsp.bucket_id, w.bucket_id);
				end
			end
			if (req_valid && !req_stall) apply_request(req);
			if (cfg_wr_en) nbuckets = cfg_wr_data;
			pending = want_q.size();
		end
	end
endmodule

>>> dv/hashed_key_set_engine_tb.sv
// Testbench top for the hashed key set engine: clock, reset, requests,
// configuration phases and verdict. Depends on hkse_pkg, the engine RTL and
// hashed_key_set_engine_chk.
module hashed_key_set_engine_tb;
	import hkse_pkg::*;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [8:0] cfg_wr_data;
	logic req_valid, req_stall, rsp_valid, rsp_stall;
	req_t req;
	rsp_t rsp;
	int fail_count, pending;
	int send_idle, recv_idle;
	int cycles;
	logic [31:0] pool [16];

	hashed_key_set_engine dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	hashed_key_set_engine_chk chk (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	always @(negedge clk) rsp_stall <= ($urandom_range(99) < recv_idle);

	task automatic send(input logic [1:0] t, input logic [31:0] k);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req.req_type <= t;
		req.key <= k;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_and_config(input logic [8:0] v);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(input int n);
		logic [31:0] k;
		logic [1:0] t;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(3) == 0) ? $urandom() : pool[$urandom_range(15)];
			t = ($urandom_range(19) == 0) ? REQ_NOP : 2'($urandom_range(2));
			send(t, k);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		send_idle = 37;
		recv_idle = 49;
		for (int i = 0; i < 16; i++) pool[i] = $urandom();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send(REQ_LOOKUP, 32'h8000_0000);
		send(REQ_INSERT, 32'h8000_0000);
		send(REQ_INSERT, 32'h7fff_ffff);
		send(REQ_INSERT, 32'h0);
		send(REQ_INSERT, 32'hffff_ffff);
		send(REQ_INSERT, 32'h7fff_ffff);
		send(REQ_LOOKUP, 32'h7fff_ffff);
		send(REQ_DELETE, 32'h7fff_ffff);
		send(REQ_LOOKUP, 32'h7fff_ffff);
		send(REQ_DELETE, 32'h1234_5678);
		send(REQ_NOP, 32'h0);
		drain_and_config(9'd1);
		for (int i = 0; i < 6; i++) send(REQ_INSERT, 32'h100 + i);
		send(REQ_LOOKUP, 32'h105);
		send(REQ_LOOKUP, 32'h0);
		drain_and_config(9'd0);
		send(REQ_LOOKUP, 32'h100);
		drain_and_config(9'h1ff);
		send(REQ_LOOKUP, 32'h100);
		send(REQ_INSERT, 32'hdead_beef);
		random_phase(150);
		drain_and_config(9'd3);
		random_phase(150);
		send_idle = 49;
		recv_idle = 37;
		drain_and_config(9'd256);
		random_phase(170);
		drain_and_config(9'($urandom_range(1, 256)));
		random_phase(150);
		send_idle = 0;
		recv_idle = 0;
		drain_and_config(9'd257);
		random_phase(180);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

>>> hashed_key_set_engine.f
rtl/hkse_pkg.sv
rtl/hkse_ctrl.sv
rtl/hkse_datapath.sv
rtl/hashed_key_set_engine.sv
rtl/hkse_checker.sv
dv/hashed_key_set_engine_chk.sv
dv/hashed_key_set_engine_tb.sv
